[rtl/vmn_pkg.sv]
`default_nettype none

package vmn_pkg;

    localparam int COMP_W         = 16;
    localparam int MAG_W          = 16;
    localparam int SQ_W           = 32;
    localparam int UNIT_SCALE_DEF = 16384;

    typedef struct packed {
        logic signed [COMP_W-1:0] comp_x;
        logic signed [COMP_W-1:0] comp_y;
        logic signed [COMP_W-1:0] comp_z;
    } vec_t;

    typedef struct packed {
        logic        [MAG_W-1:0]  magnitude;
        logic signed [COMP_W-1:0] unit_x;
        logic signed [COMP_W-1:0] unit_y;
        logic signed [COMP_W-1:0] unit_z;
    } nrm_t;

endpackage

`default_nettype wire

[rtl/vmn_sqrt.sv]
`default_nettype none

module vmn_sqrt
    import vmn_pkg::*;
#(
    parameter int TAG_W = 3 * COMP_W
)
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [SQ_W-1:0]   n,
    input  wire logic [TAG_W-1:0]  tag_in,
    output logic      [MAG_W-1:0]  root,
    output logic      [TAG_W-1:0]  tag_out
);

    localparam int RW = SQ_W + 2;

    logic [RW-1:0]    rem_reg  [1:MAG_W];
    logic [MAG_W-1:0] root_reg [1:MAG_W];
    logic [TAG_W-1:0] tag_reg  [1:MAG_W];

    logic [RW-1:0]    st_rem  [0:MAG_W-1];
    logic [MAG_W-1:0] st_root [0:MAG_W-1];
    logic [TAG_W-1:0] st_tag  [0:MAG_W-1];

    assign st_rem[0]  = RW'(n);
    assign st_root[0] = '0;
    assign st_tag[0]  = tag_in;

    for (genvar i = 1; i < MAG_W; i++) begin : g_link
        assign st_rem[i]  = rem_reg[i];
        assign st_root[i] = root_reg[i];
        assign st_tag[i]  = tag_reg[i];
    end

    // Each stage settles one root bit, most significant first.
    for (genvar i = 0; i < MAG_W; i++) begin : g_stage
        localparam int K = MAG_W - 1 - i;
        logic [RW-1:0]    trial;
        logic [RW-1:0]    rem_next;
        logic [MAG_W-1:0] root_next;

        always_comb
        begin
            trial = (RW'(st_root[i]) << (K + 1)) | (RW'(1) << (2 * K));
            if (st_rem[i] >= trial)
            begin
                rem_next  = st_rem[i] - trial;
                root_next = st_root[i] | (MAG_W'(1) << K);
            end
            else
            begin
                rem_next  = st_rem[i];
                root_next = st_root[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= rem_next;
                root_reg[i+1] <= root_next;
                tag_reg[i+1]  <= st_tag[i];
            end
        end
    end

    assign root    = root_reg[MAG_W];
    assign tag_out = tag_reg[MAG_W];

endmodule

`default_nettype wire

[rtl/vmn_div.sv]
`default_nettype none

module vmn_div
    import vmn_pkg::*;
#(
    parameter int UNIT_SCALE = UNIT_SCALE_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [COMP_W-1:0] comp,
    input  wire logic        [MAG_W-1:0]  mag,
    output logic signed      [COMP_W-1:0] quo
);

    localparam int QW = $clog2(UNIT_SCALE + 1);
    localparam int NW = COMP_W + QW;
    localparam int RW = NW + 1;

    logic [COMP_W-1:0] abs_c;
    logic [RW-1:0]     rem_reg  [0:QW];
    logic [QW-1:0]     q_reg    [0:QW];
    logic [MAG_W-1:0]  d_reg    [0:QW];
    logic              neg_reg  [0:QW];
    logic              zero_reg [0:QW];
    logic [COMP_W-1:0] qx;
    logic [COMP_W-1:0] quo_next;
    logic [COMP_W-1:0] quo_reg;

    assign abs_c = comp[COMP_W-1] ? COMP_W'(-comp) : comp;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= RW'(RW'(abs_c) * RW'(UNIT_SCALE));
            q_reg[0]    <= '0;
            d_reg[0]    <= mag;
            neg_reg[0]  <= comp[COMP_W-1];
            zero_reg[0] <= (mag == '0);
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar i = 0; i < QW; i++) begin : g_stage
        localparam int J = QW - 1 - i;
        logic [RW-1:0] dsh;

        assign dsh = RW'(d_reg[i]) << J;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[i] >= dsh)
                begin
                    rem_reg[i+1] <= rem_reg[i] - dsh;
                    q_reg[i+1]   <= q_reg[i] | (QW'(1) << J);
                end
                else
                begin
                    rem_reg[i+1] <= rem_reg[i];
                    q_reg[i+1]   <= q_reg[i];
                end
                d_reg[i+1]    <= d_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    assign qx = COMP_W'(q_reg[QW]);

    always_comb
    begin
        if (zero_reg[QW])
        begin
            quo_next = '0;
        end
        else if (neg_reg[QW])
        begin
            quo_next = -qx;
        end
        else
        begin
            quo_next = qx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

[rtl/vector_magnitude_normalize.sv]
// An accepted item passes in order through the square, sum, square-root and divider
// registers, with its magnitude carried in a delay line beside the dividers.
// Throughput: one item per cycle; the whole pipeline holds only while the output
// register is full and not taken.
// Reset: rst_n clears all valid flags asynchronously; datapath registers are not reset.
`default_nettype none

module vector_magnitude_normalize
    import vmn_pkg::*;
#(
    parameter int UNIT_SCALE = UNIT_SCALE_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic vec_valid,
    output logic      vec_ready,
    input  wire vec_t vec,
    output logic      nrm_valid,
    input  wire logic nrm_ready,
    output nrm_t      nrm
);

    localparam int QW = $clog2(UNIT_SCALE + 1);
    localparam int DL = QW + 2;
    localparam int L  = 2 + MAG_W + DL;

    logic          adv;
    logic [L-1:0]  vld_reg;
    logic [L-1:0]  vld_next;

    logic [SQ_W-1:0] sq_reg [0:2];
    vec_t            va_reg;
    logic [SQ_W-1:0] sum_reg;
    vec_t            vb_reg;

    logic [MAG_W-1:0]    root;
    logic [3*COMP_W-1:0] tag_out;
    vec_t                vs;
    logic [MAG_W-1:0]    mag_reg [0:DL-1];

    logic signed [COMP_W-1:0] ux;
    logic signed [COMP_W-1:0] uy;
    logic signed [COMP_W-1:0] uz;

    assign adv       = !vld_reg[L-1] || nrm_ready;
    assign vec_ready = adv;
    assign vld_next  = {vld_reg[L-2:0], vec_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0] <= SQ_W'(vec.comp_x * vec.comp_x);
            sq_reg[1] <= SQ_W'(vec.comp_y * vec.comp_y);
            sq_reg[2] <= SQ_W'(vec.comp_z * vec.comp_z);
            va_reg    <= vec;
            sum_reg   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            vb_reg    <= va_reg;
        end
    end

    vmn_sqrt #(
        .TAG_W (3 * COMP_W)
    ) u_sqrt (
        .clk     (clk),
        .en      (adv),
        .n       (sum_reg),
        .tag_in  (vb_reg),
        .root    (root),
        .tag_out (tag_out)
    );

    assign vs = vec_t'(tag_out);

    vmn_div #(.UNIT_SCALE (UNIT_SCALE)) u_div_x (
        .clk (clk), .en (adv), .comp (vs.comp_x), .mag (root), .quo (ux)
    );

    vmn_div #(.UNIT_SCALE (UNIT_SCALE)) u_div_y (
        .clk (clk), .en (adv), .comp (vs.comp_y), .mag (root), .quo (uy)
    );

    vmn_div #(.UNIT_SCALE (UNIT_SCALE)) u_div_z (
        .clk (clk), .en (adv), .comp (vs.comp_z), .mag (root), .quo (uz)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg[0] <= root;
            for (int i = 1; i < DL; i++)
            begin
                mag_reg[i] <= mag_reg[i-1];
            end
        end
    end

    assign nrm_valid     = vld_reg[L-1];
    assign nrm.magnitude = mag_reg[DL-1];
    assign nrm.unit_x    = ux;
    assign nrm.unit_y    = uy;
    assign nrm.unit_z    = uz;

    a_zero_mag: assert property (@(posedge clk) disable iff (!rst_n)
        nrm_valid && (nrm.magnitude == '0) |->
            (nrm.unit_x == '0) && (nrm.unit_y == '0) && (nrm.unit_z == '0))
        else $error("zero magnitude with nonzero unit component");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        nrm_valid |->
            ($signed(nrm.unit_x) <= $signed(18'(UNIT_SCALE))) &&
            ($signed(nrm.unit_x) >= -$signed(18'(UNIT_SCALE))))
        else $error("unit_x outside unit range");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !vec_ready |-> nrm_valid && !nrm_ready)
        else $error("input stalled without output back-pressure");

endmodule

`default_nettype wire

[dv/tb_vector_magnitude_normalize.sv]
`default_nettype none

module tb_vector_magnitude_normalize;
    import vmn_pkg::*;

    class nrm_scoreboard;
        nrm_t pending[$];
        int   n_err;
        int   n_in;
        int   n_out;

        function automatic logic [15:0] isqrt(logic [31:0] n);
            logic [31:0] root;
            logic [31:0] bitv;
            root = 0;
            bitv = 32'h4000_0000;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= root + bitv)
                begin
                    n = n - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root[15:0];
        endfunction

        function automatic logic signed [15:0] scaled(logic signed [15:0] c,
                                                      logic [15:0] m);
            longint num;
            longint q;
            num = longint'(UNIT_SCALE_DEF) * longint'(c);
            q = num / longint'({16'd0, m});
            return q[15:0];
        endfunction

        function void note_vec(vec_t v);
            nrm_t r;
            logic [31:0] sq;
            sq = 32'(int'(v.comp_x) * int'(v.comp_x)) + 32'(int'(v.comp_y) * int'(v.comp_y))
                 + 32'(int'(v.comp_z) * int'(v.comp_z));
            r.magnitude = isqrt(sq);
            if (r.magnitude != 0)
            begin
                r.unit_x = scaled(v.comp_x, r.magnitude);
                r.unit_y = scaled(v.comp_y, r.magnitude);
                r.unit_z = scaled(v.comp_z, r.magnitude);
            end
            else
            begin
                r.unit_x = 0;
                r.unit_y = 0;
                r.unit_z = 0;
            end
            pending.push_back(r);
            n_in++;
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_out);
            n_err++;
        endtask

        task check_nrm(nrm_t got);
            nrm_t want;
            if (pending.size() == 0)
            begin
                report("unexpected result", 1, 0);
                return;
            end
            want = pending.pop_front();
            if (got.magnitude != want.magnitude)
                report("magnitude", got.magnitude, want.magnitude);
            if (got.unit_x != want.unit_x) report("unit_x", got.unit_x, want.unit_x);
            if (got.unit_y != want.unit_y) report("unit_y", got.unit_y, want.unit_y);
            if (got.unit_z != want.unit_z) report("unit_z", got.unit_z, want.unit_z);
            n_out++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic vec_valid;
    logic vec_ready;
    vec_t vec;
    logic nrm_valid;
    logic nrm_ready;
    nrm_t nrm;
    logic stim_done;

    nrm_scoreboard sb;

    vector_magnitude_normalize uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vec_valid (vec_valid),
        .vec_ready (vec_ready),
        .vec       (vec),
        .nrm_valid (nrm_valid),
        .nrm_ready (nrm_ready),
        .nrm       (nrm)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    task send_vec(vec_t v, bit may_idle);
        int g;
        g = may_idle ? gap_len() : 0;
        if (g > 0)
        begin
            vec_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        vec_valid <= 1'b1;
        vec <= v;
        @(posedge clk);
        while (!vec_ready) @(posedge clk);
        sb.note_vec(v);
    endtask

    function automatic vec_t mk(int x, int y, int z);
        vec_t v;
        v.comp_x = 16'(x);
        v.comp_y = 16'(y);
        v.comp_z = 16'(z);
        return v;
    endfunction

    function automatic logic [15:0] rand_comp();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            3: return 16'(int'($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        vec_t v;
        bit calm;
        sb = new();
        rst_n = 0;
        vec_valid = 0;
        vec = '0;
        stim_done = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_vec(mk(0, 0, 0), 0);
        send_vec(mk(32767, 0, 0), 0);
        send_vec(mk(-32768, 0, 0), 0);
        send_vec(mk(0, -32768, 0), 0);
        send_vec(mk(0, 0, 32767), 0);
        send_vec(mk(-32768, -32768, -32768), 0);
        send_vec(mk(32767, 32767, 32767), 0);
        send_vec(mk(-32768, 32767, -32768), 0);
        send_vec(mk(1, 0, 0), 0);
        send_vec(mk(-1, 0, 0), 0);
        send_vec(mk(1, 1, 1), 0);
        send_vec(mk(3, 4, 0), 0);
        send_vec(mk(-3, 4, 12), 0);
        send_vec(mk(23170, 23170, 0), 0);
        send_vec(mk(-23170, 23171, 0), 0);
        send_vec(mk(21000, -21000, 21000), 0);
        send_vec(mk(0, 0, -1), 0);
        send_vec(mk(16'h5555, 16'hAAAA, 16'h5555), 0);

        vec_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);

        for (int i = 0; i < 1750; i++)
        begin
            if (i == 900)
            begin
                vec_valid <= 1'b0;
                while (sb.pending.size() != 0) @(posedge clk);
            end
            calm = (i / 200) % 3 == 1;
            v.comp_x = rand_comp();
            v.comp_y = rand_comp();
            v.comp_z = ($urandom_range(0, 4) == 0) ? 16'd0 : rand_comp();
            send_vec(v, !calm);
        end
        vec_valid <= 1'b0;
        stim_done <= 1'b1;
    end

    initial
    begin
        nrm_ready = 0;
        @(posedge rst_n);
        forever
        begin
            int g;
            @(posedge clk);
            g = (($urandom_range(0, 3) == 0) && ($time / 8000) % 4 != 2) ? gap_len() : 0;
            if (g > 0)
            begin
                nrm_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            nrm_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && nrm_valid && nrm_ready)
            sb.check_nrm(nrm);
    end

    initial
    begin
        wait (stim_done === 1'b1);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Covered %0d vectors (%0d results) with extremes, zero vector and 2-D items,",
                 sb.n_in, sb.n_out);
        $display("under random input gaps and output stalls.");
        if (sb.n_err == 0)
            $display("tb_vector_magnitude_normalize: done, clean");
        else
            $display("tb_vector_magnitude_normalize: done, errors");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb_vector_magnitude_normalize: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
